/* design/midi_byte_stream_parser_defines.svh */
// ---------------------------------------------------------------------------
// MIDI byte stream parser: assertion macros
// Shared helpers for the concurrent checks of the parser.
// ---------------------------------------------------------------------------
`ifndef MIDI_BYTE_STREAM_PARSER_DEFINES_SVH
`define MIDI_BYTE_STREAM_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define MBSP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held
`define MBSP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/mbsp_pkg.sv */
// ---------------------------------------------------------------------------
// mbsp_pkg
// Types and constants shared by the MIDI byte stream parser modules.
// ---------------------------------------------------------------------------
package mbsp_pkg;

  // Default sysex capture depth in bytes
  localparam int unsigned BufferDepthDefault = 32;

  // Special status bytes
  localparam logic [7:0] StatusSysexStart = 8'hF0;
  localparam logic [7:0] StatusSysexEnd   = 8'hF7;
  localparam logic [7:0] RealtimeFirst    = 8'hF8;

  // Result kind codes
  localparam logic KindChannel = 1'b0;
  localparam logic KindSysex   = 1'b1;

  // Parser mode
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_SYSEX = 2'd1,
    MODE_MSG   = 2'd2
  } parse_mode_e;

  // What one accepted byte asks of the output side
  typedef struct packed {
    logic       msg_valid;    // a complete channel message
    logic [7:0] status_byte;
    logic [7:0] first_data;
    logic [6:0] second_data;
    logic       dump_valid;   // sysex end: read the store out
  } emit_t;

  // One result item held in the output register
  typedef struct packed {
    logic       kind;
    logic [7:0] status_byte;
    logic [7:0] first_data;
    logic [6:0] second_data;
    logic       last_of_run;
  } result_t;

endpackage

/* design/mbsp_store.sv */
// ---------------------------------------------------------------------------
// mbsp_store
// Sysex capture memory: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module mbsp_store #(
  parameter int unsigned DEPTH = mbsp_pkg::BufferDepthDefault,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port; data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* design/mbsp_parse.sv */
// ---------------------------------------------------------------------------
// mbsp_parse
// Byte parser: tracks the message mode, fills the sysex store and flags
// finished channel messages and sysex ends.
// ---------------------------------------------------------------------------
module mbsp_parse #(
  parameter int unsigned DEPTH = mbsp_pkg::BufferDepthDefault,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_fire_i,
  input  logic [7:0]      rx_byte_i,
  output logic            wr_en_o,
  output logic [AW-1:0]   wr_addr_o,
  output logic [7:0]      wr_data_o,
  output mbsp_pkg::emit_t emit_o,
  output logic [AW-1:0]   dump_end_o
);

  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam logic [FW-1:0] FillFull = FW'(DEPTH);
  localparam logic [FW-1:0] FillOne  = FW'(1);
  localparam logic [FW-1:0] FillTwo  = FW'(2);
  localparam logic [FW-1:0] FillDone = FW'(3);

  // Data byte counts per status
  localparam logic [1:0] NeedNone = 2'd0;
  localparam logic [1:0] NeedOne  = 2'd1;
  localparam logic [1:0] NeedTwo  = 2'd2;

  function automatic logic [1:0] need_count(input logic [7:0] status);
    logic [3:0] nib;
    nib = status[7:4];
    if (nib inside {4'h8, 4'h9, 4'hB, 4'hE}) begin
      return NeedTwo;
    end else if (nib inside {4'hC, 4'hD}) begin
      return NeedOne;
    end
    return NeedNone;
  endfunction

  mbsp_pkg::parse_mode_e mode_q, mode_d;
  logic [7:0]    status_q, status_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [6:0]    held_q, held_d;
  logic [1:0]    need;
  logic          has_room;

  // Mode and message registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= mbsp_pkg::MODE_IDLE;
      status_q <= '0;
      fill_q   <= FillOne;
      held_q   <= '0;
    end else begin
      mode_q   <= mode_d;
      status_q <= status_d;
      fill_q   <= fill_d;
      held_q   <= held_d;
    end
  end

  assign need     = need_count(status_q);
  assign has_room = (fill_q < FillFull);

  // Next state and store writes
  always_comb begin
    mode_d     = mode_q;
    status_d   = status_q;
    fill_d     = fill_q;
    held_d     = held_q;
    wr_en_o    = 1'b0;
    wr_addr_o  = fill_q[AW-1:0];
    wr_data_o  = rx_byte_i;
    emit_o     = '0;
    dump_end_o = fill_q[AW-1:0];

    if (in_fire_i && (rx_byte_i < mbsp_pkg::RealtimeFirst)) begin
      if (rx_byte_i[7]) begin
        if (rx_byte_i == mbsp_pkg::StatusSysexStart) begin
          // start capture with the start byte at entry zero
          mode_d    = mbsp_pkg::MODE_SYSEX;
          wr_en_o   = 1'b1;
          wr_addr_o = '0;
          wr_data_o = mbsp_pkg::StatusSysexStart;
          fill_d    = FillOne;
        end else if (rx_byte_i == mbsp_pkg::StatusSysexEnd) begin
          // close capture: if open with room, store the end byte, then read it all out
          if ((mode_q == mbsp_pkg::MODE_SYSEX) && has_room) begin
            wr_en_o           = 1'b1;
            wr_data_o         = mbsp_pkg::StatusSysexEnd;
            emit_o.dump_valid = 1'b1;
          end
          mode_d = mbsp_pkg::MODE_IDLE;
          fill_d = FillOne;
        end else begin
          mode_d   = mbsp_pkg::MODE_MSG;
          status_d = rx_byte_i;
          fill_d   = FillOne;
        end
      end else begin
        case (mode_q)
          mbsp_pkg::MODE_SYSEX: begin
            if (has_room) begin
              wr_en_o = 1'b1;
              fill_d  = fill_q + FillOne;
            end else begin
              // overflow drops the capture
              mode_d = mbsp_pkg::MODE_IDLE;
              fill_d = FillOne;
            end
          end
          mbsp_pkg::MODE_MSG: begin
            if (need != NeedNone) begin
              emit_o.status_byte = status_q;
              if (fill_q <= FillOne) begin
                held_d = rx_byte_i[6:0];
                fill_d = FillTwo;
                if (need == NeedOne) begin
                  emit_o.msg_valid  = 1'b1;
                  emit_o.first_data = {1'b0, rx_byte_i[6:0]};
                  mode_d            = mbsp_pkg::MODE_IDLE;
                end
              end else begin
                emit_o.msg_valid   = 1'b1;
                emit_o.first_data  = {1'b0, held_q};
                emit_o.second_data = rx_byte_i[6:0];
                fill_d             = FillDone;
                mode_d             = mbsp_pkg::MODE_IDLE;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

/* design/mbsp_drain.sv */
// ---------------------------------------------------------------------------
// mbsp_drain
// Output side: reads the sysex store out one byte a cycle while the output
// register is free, and holds results in it until the downstream takes them.
// ---------------------------------------------------------------------------
module mbsp_drain #(
  parameter int unsigned DEPTH = mbsp_pkg::BufferDepthDefault,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mbsp_pkg::emit_t   emit_i,
  input  logic [AW-1:0]     dump_end_i,
  output logic              rd_en_o,
  output logic [AW-1:0]     rd_addr_o,
  input  logic [7:0]        rd_data_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output mbsp_pkg::result_t out_o,
  output logic              busy_o,
  output logic              in_ready_o
);

  logic          busy_q, busy_d;
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic [AW-1:0] end_q, end_d;
  logic          issued_all_q, issued_all_d;
  logic          pend_q, pend_d;
  logic          pend_last_q, pend_last_d;
  logic          out_valid_q, out_valid_d;
  mbsp_pkg::result_t out_q, out_d;
  logic          out_free;
  logic          load_pend;
  logic          issue;
  logic          at_end;

  assign out_free  = !out_valid_q || out_ready_i;
  assign load_pend = pend_q && out_free;
  assign issue     = busy_q && !issued_all_q && (!pend_q || load_pend);
  assign at_end    = (rd_addr_q == end_q);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      rd_addr_q    <= '0;
      end_q        <= '0;
      issued_all_q <= 1'b0;
      pend_q       <= 1'b0;
      pend_last_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      busy_q       <= busy_d;
      rd_addr_q    <= rd_addr_d;
      end_q        <= end_d;
      issued_all_q <= issued_all_d;
      pend_q       <= pend_d;
      pend_last_q  <= pend_last_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Read sequencing and output loading
  always_comb begin
    busy_d       = busy_q;
    rd_addr_d    = rd_addr_q;
    end_d        = end_q;
    issued_all_d = issued_all_q;
    pend_d       = pend_q;
    pend_last_d  = pend_last_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;

    // start a readout at the sysex end byte
    if (emit_i.dump_valid) begin
      busy_d       = 1'b1;
      rd_addr_d    = '0;
      end_d        = dump_end_i;
      issued_all_d = 1'b0;
    end

    // a finished channel message goes straight to the output register
    if (emit_i.msg_valid) begin
      out_valid_d       = 1'b1;
      out_d.kind        = mbsp_pkg::KindChannel;
      out_d.status_byte = emit_i.status_byte;
      out_d.first_data  = emit_i.first_data;
      out_d.second_data = emit_i.second_data;
      out_d.last_of_run = 1'b1;
    end

    // move read data into the output register
    if (load_pend) begin
      pend_d            = 1'b0;
      out_valid_d       = 1'b1;
      out_d.kind        = mbsp_pkg::KindSysex;
      out_d.status_byte = mbsp_pkg::StatusSysexStart;
      out_d.first_data  = rd_data_i;
      out_d.second_data = '0;
      out_d.last_of_run = pend_last_q;
      if (pend_last_q) begin
        busy_d = 1'b0;
      end
    end

    // issue the next read
    if (issue) begin
      pend_d      = 1'b1;
      pend_last_d = at_end;
      rd_addr_d   = rd_addr_q + AW'(1);
      if (at_end) begin
        issued_all_d = 1'b1;
      end
    end
  end

  assign rd_en_o     = issue;
  assign rd_addr_o   = rd_addr_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign busy_o      = busy_q;
  assign in_ready_o  = !busy_q && out_free;

endmodule

/* design/midi_byte_stream_parser.sv */
// ---------------------------------------------------------------------------
// midi_byte_stream_parser
// MIDI byte parser without running status: channel messages and captured
// system-exclusive runs out of a byte stream.
// ---------------------------------------------------------------------------
//  Channel   Dir  tdata                                      tuser  tlast
//  s_axis    in   [7:0] rx_byte                              -      -
//  m_axis    out  [7:0] status, [15:8] first, [22:16] second kind   last_of_run
//
// A byte is taken while no capture is being read out and the output register
// is free; a byte that completes a channel message puts its result in the
// output register at the edge that accepts it. A sysex end byte holds the
// input while the capture, end byte included, is read from the registered
// store one entry a cycle; results leave one a cycle when not stalled.
// Reset clears the control state at once; the store is not cleared.
// A low m_axis_tready holds the output register and with it the input side.
// ---------------------------------------------------------------------------
`include "midi_byte_stream_parser_defines.svh"

module midi_byte_stream_parser #(
  parameter int unsigned BUFFER_DEPTH = mbsp_pkg::BufferDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] status_byte, [15:8] first_data,
                                      // [22:16] second_data, [23] zero
  output logic        m_axis_tuser,   // [0] kind
  output logic        m_axis_tlast    // last_of_run
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);

  logic              in_fire;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [7:0]        rd_data;
  logic [AW-1:0]     dump_end;
  logic              drain_busy;
  mbsp_pkg::emit_t   emit;
  mbsp_pkg::result_t result;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  mbsp_parse #(
    .DEPTH (BUFFER_DEPTH)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .rx_byte_i  (s_axis_tdata),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .emit_o     (emit),
    .dump_end_o (dump_end)
  );

  mbsp_store #(
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  mbsp_drain #(
    .DEPTH (BUFFER_DEPTH)
  ) u_drain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .dump_end_i  (dump_end),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_o       (result),
    .busy_o      (drain_busy),
    .in_ready_o  (s_axis_tready)
  );

  // Pack the result onto the output stream
  assign m_axis_tdata = {1'b0, result.second_data, result.first_data, result.status_byte};
  assign m_axis_tuser = result.kind;
  assign m_axis_tlast = result.last_of_run;

  // Checks
  `MBSP_ASSERT_IMP(a_no_input_in_drain, clk_i, rst_ni, drain_busy, !s_axis_tready, "input taken during readout")
  `MBSP_ASSERT_NXT(a_end_starts_drain, clk_i, rst_ni, emit.dump_valid, drain_busy, "sysex end did not start a readout")
  `MBSP_ASSERT_IMP(a_store_port_excl, clk_i, rst_ni, rd_en, !wr_en, "store read and write overlap")
  `MBSP_ASSERT_IMP(a_channel_single, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == mbsp_pkg::KindChannel), m_axis_tlast && !m_axis_tdata[15], "bad channel result")

endmodule

/* dv/midi_byte_stream_parser_tb.sv */
// ---------------------------------------------------------------------------
// midi_byte_stream_parser_tb
// Self-checking bench for the MIDI byte parser. Bytes go in on the slave
// stream; a behavioural copy of the parser predicts the channel messages and
// sysex runs each accepted request should cause, and every result taken from
// the master stream is checked field by field against the oldest prediction.
// Directed cases, sysex capacity limits, long output hold-off and random
// traffic are run; the random traffic under several idle and stall mixes.
// ---------------------------------------------------------------------------
module midi_byte_stream_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth       = mbsp_pkg::BufferDepthDefault;
  localparam int unsigned DrainCycles = 2 * Depth + 8;
  localparam int unsigned RandomItems = 6;  // per idling phase

  // Channel message status codes (upper nibble, channel in low nibble)
  localparam logic [7:0] StatusNoteOff      = 8'h80;
  localparam logic [7:0] StatusNoteOn       = 8'h90;
  localparam logic [7:0] StatusPolyPressure = 8'hA0;
  localparam logic [7:0] StatusControl      = 8'hB0;
  localparam logic [7:0] StatusProgram      = 8'hC0;
  localparam logic [7:0] StatusChanPressure = 8'hD0;
  localparam logic [7:0] StatusPitchWheel   = 8'hE0;
  localparam logic [7:0] StatusCommonFirst  = 8'hF1;
  localparam logic [7:0] StatusCommonLast   = 8'hF6;
  localparam logic [7:0] RealtimeLast       = 8'hFF;
  localparam logic [7:0] StatusMask         = 8'hF0;
  localparam logic [7:0] DataMax            = 8'h7F;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  midi_byte_stream_parser #(
    .BUFFER_DEPTH(Depth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // Clock: 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off_request = 0;
  int unsigned hold_off_left = 0;

  mbsp_pkg::result_t pending_results[$];

  // Parser shadow state
  mbsp_pkg::parse_mode_e rx_mode = mbsp_pkg::MODE_IDLE;
  logic [7:0]  msg_status = '0;
  int unsigned fill_count = 1;
  logic [6:0]  held_data1 = '0;
  logic [7:0]  sysex_copy [Depth];

  // Data bytes a channel status takes; zero when the length is unknown
  function automatic int unsigned data_bytes_needed(logic [7:0] st);
    case (st & StatusMask)
      StatusNoteOff, StatusNoteOn, StatusControl, StatusPitchWheel: return 2;
      StatusProgram, StatusChanPressure: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic void add_result(logic kind, logic [7:0] st, logic [7:0] d1,
                                     logic [6:0] d2, logic last);
    mbsp_pkg::result_t r;
    r.kind        = kind;
    r.status_byte = st;
    r.first_data  = d1;
    r.second_data = d2;
    r.last_of_run = last;
    pending_results.push_back(r);
  endfunction

  // Advance the shadow parser by one accepted byte, queueing its results
  function automatic void predict_rx_byte(logic [7:0] b);
    int unsigned need;
    if (b >= mbsp_pkg::RealtimeFirst) return;
    if (b[7]) begin
      if (b == mbsp_pkg::StatusSysexStart) begin
        rx_mode       = mbsp_pkg::MODE_SYSEX;
        sysex_copy[0] = mbsp_pkg::StatusSysexStart;
        fill_count    = 1;
      end else if (b == mbsp_pkg::StatusSysexEnd) begin
        // dump only when the end byte still fits
        if (rx_mode == mbsp_pkg::MODE_SYSEX && fill_count < Depth) begin
          sysex_copy[fill_count] = mbsp_pkg::StatusSysexEnd;
          fill_count++;
          for (int unsigned i = 0; i < fill_count; i++)
            add_result(mbsp_pkg::KindSysex, mbsp_pkg::StatusSysexStart, sysex_copy[i],
                       '0, (i + 1 == fill_count));
        end
        rx_mode    = mbsp_pkg::MODE_IDLE;
        fill_count = 1;
      end else begin
        rx_mode    = mbsp_pkg::MODE_MSG;
        msg_status = b;
        fill_count = 1;
      end
      return;
    end
    case (rx_mode)
      mbsp_pkg::MODE_SYSEX: begin
        if (fill_count < Depth) begin
          sysex_copy[fill_count] = b;
          fill_count++;
        end else begin
          rx_mode    = mbsp_pkg::MODE_IDLE;
          fill_count = 1;
        end
      end
      mbsp_pkg::MODE_MSG: begin
        need = data_bytes_needed(msg_status);
        if (need == 0) return;
        if (fill_count <= 1) begin
          held_data1 = b[6:0];
          fill_count = 2;
          if (need == 1) begin
            add_result(mbsp_pkg::KindChannel, msg_status, b, '0, 1'b1);
            rx_mode = mbsp_pkg::MODE_IDLE;
          end
        end else begin
          add_result(mbsp_pkg::KindChannel, msg_status, {1'b0, held_data1}, b[6:0],
                     1'b1);
          fill_count = 3;
          rx_mode    = mbsp_pkg::MODE_IDLE;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    mbsp_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tdata %h user %b last %b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", {7'd0, want.kind}, {7'd0, m_axis_tuser});
        check_field("status_byte", want.status_byte, m_axis_tdata[7:0]);
        check_field("first_data", want.first_data, m_axis_tdata[15:8]);
        check_field("second_data", {1'b0, want.second_data}, {1'b0, m_axis_tdata[22:16]});
        check_field("tdata pad", 8'd0, {7'd0, m_axis_tdata[23]});
        check_field("last_of_run", {7'd0, want.last_of_run}, {7'd0, m_axis_tlast});
      end
    end
  end

  // Receiver: random stall, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_off_request != 0) begin
      hold_off_left    = hold_off_request;
      hold_off_request = 0;
    end
    if (hold_off_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_off_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // One request on the slave stream; called and returns at a falling edge.
  // tvalid is left high so a back-to-back request keeps it up.
  task automatic send_rx_byte(input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    predict_rx_byte(b);
    if (b < mbsp_pkg::RealtimeFirst) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic send_sysex(int unsigned len);
    send_rx_byte(mbsp_pkg::StatusSysexStart);
    repeat (len) send_rx_byte(8'($urandom_range(127)));
    send_rx_byte(mbsp_pkg::StatusSysexEnd);
  endtask

  // Every channel operation, on channel 0 or 15 in turn, data at 0 and 127.
  // Two data bytes each time: the second is idle data for one-byte messages, both for poly pressure.
  task automatic test_channel_messages();
    logic [7:0] ops [7] = '{StatusNoteOff, StatusNoteOn, StatusPolyPressure,
                            StatusControl, StatusProgram, StatusChanPressure,
                            StatusPitchWheel};
    foreach (ops[i]) begin
      send_rx_byte(ops[i] | ((i % 2 == 1) ? 8'h0F : 8'h00));
      send_rx_byte((i % 2 == 1) ? 8'h00 : DataMax);
      send_rx_byte((i % 2 == 1) ? DataMax : 8'h00);
    end
    wait_drained();
  endtask

  task automatic test_special_cases();
    // realtime bytes inside a message and while idle
    send_rx_byte(StatusNoteOn | 8'h03);
    send_rx_byte(8'h3C);
    send_rx_byte(mbsp_pkg::RealtimeFirst);
    send_rx_byte(DataMax);
    send_rx_byte(RealtimeLast);
    // idle data and a stray end byte
    send_rx_byte(8'h55);
    send_rx_byte(mbsp_pkg::StatusSysexEnd);
    // new status cuts a partial message
    send_rx_byte(StatusControl | 8'h01);
    send_rx_byte(8'h07);
    send_rx_byte(StatusProgram | 8'h05);
    send_rx_byte(8'h22);
    // system common: data swallowed
    send_rx_byte(StatusCommonFirst);
    send_rx_byte(8'h01);
    send_rx_byte(StatusCommonLast);
    send_rx_byte(8'h02);
    // new status aborts a capture
    send_rx_byte(mbsp_pkg::StatusSysexStart);
    send_rx_byte(8'h11);
    send_rx_byte(StatusPitchWheel | 8'h0A);
    send_rx_byte(8'h40);
    send_rx_byte(8'h50);
    // realtime inside a capture, then an empty capture
    send_rx_byte(mbsp_pkg::StatusSysexStart);
    send_rx_byte(8'h01);
    send_rx_byte(8'hFA);
    send_rx_byte(mbsp_pkg::StatusSysexEnd);
    send_rx_byte(mbsp_pkg::StatusSysexStart);
    send_rx_byte(mbsp_pkg::StatusSysexEnd);
    wait_drained();
  endtask

  task automatic test_sysex_limits();
    // longest run that fits: start, data, end fill the store exactly
    send_sysex(Depth - 2);
    wait_drained();
    // end byte arriving with a full store: nothing comes out
    send_sysex(Depth - 1);
    // data byte on a full store aborts; what follows is idle data
    send_rx_byte(mbsp_pkg::StatusSysexStart);
    repeat (Depth) send_rx_byte(8'($urandom_range(127)));
    send_rx_byte(8'h12);
    send_rx_byte(mbsp_pkg::StatusSysexEnd);
    // parser still works afterwards
    send_rx_byte(StatusNoteOn);
    send_rx_byte(8'h01);
    send_rx_byte(8'h02);
    wait_drained();
  endtask

  // Output held off for a long stretch while requests keep coming
  task automatic test_output_hold_off();
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_off_request = 300;
    send_sysex(24);
    for (int i = 0; i < 6; i++) begin
      send_rx_byte(StatusNoteOn | 8'($urandom_range(15)));
      send_rx_byte(8'($urandom_range(127)));
      send_rx_byte(8'($urandom_range(127)));
    end
    send_sysex(5);
    wait_drained();
  endtask

  // Mostly well-formed messages and captures, with broken ones and noise
  task automatic run_random_traffic(int unsigned count);
    int unsigned goal, pick, len;
    logic [7:0] st;
    goal = items_sent + count;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
        send_rx_byte(st);
        len = (data_bytes_needed(st) == 0) ? $urandom_range(0, 2) : data_bytes_needed(st);
        repeat (len) begin
          if ($urandom_range(9) == 0)
            send_rx_byte(8'($urandom_range(mbsp_pkg::RealtimeFirst, 255)));
          send_rx_byte(8'($urandom_range(127)));
        end
      end else if (pick < 65) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(Depth - 4, Depth + 1)
                                       : $urandom_range(0, 8);
        send_sysex(len);
      end else if (pick < 73) begin
        send_rx_byte(8'($urandom_range(StatusCommonFirst, StatusCommonLast)));
        repeat ($urandom_range(0, 2)) send_rx_byte(8'($urandom_range(127)));
      end else if (pick < 85) begin
        // cut short: a partial message or capture, ended by whatever follows
        if ($urandom_range(1) == 0) begin
          send_rx_byte({1'b1, 3'($urandom_range(0, 6)), 4'($urandom)});
          repeat ($urandom_range(0, 1)) send_rx_byte(8'($urandom_range(127)));
        end else begin
          send_rx_byte(mbsp_pkg::StatusSysexStart);
          repeat ($urandom_range(0, 6)) send_rx_byte(8'($urandom_range(127)));
        end
      end else begin
        send_rx_byte(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic test_random_idling();
    int unsigned send_mix [4] = '{0, 61, 0, 37};
    int unsigned recv_mix [4] = '{0, 0, 61, 37};
    foreach (send_mix[i]) begin
      send_idle_pct  = send_mix[i];
      recv_stall_pct = recv_mix[i];
      run_random_traffic(RandomItems);
      wait_drained();
    end
  endtask

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_channel_messages();
    test_special_cases();
    send_idle_pct  = 37;
    recv_stall_pct = 37;
    test_sysex_limits();
    test_output_hold_off();
    test_random_idling();

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
